>>> hdl/lpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpr_pkg - shared types and codes for the LRU page replacement table
// Request and result formats, request kinds, status codes, default sizes.
// ----------------------------------------------------------------------------
package lpr_pkg;

	localparam int PageWidth       = 36;
	localparam int DefaultCapacity = 16;
	localparam int DefaultPageBits = 36;

	localparam logic [1:0] KIND_TOUCH  = 2'd0;
	localparam logic [1:0] KIND_INSERT = 2'd1;
	localparam logic [1:0] KIND_EVICT  = 2'd2;

	localparam logic [1:0] ST_OK             = 2'd0;
	localparam logic [1:0] ST_TOUCH_ABSENT   = 2'd1;
	localparam logic [1:0] ST_INSERT_PRESENT = 2'd2;
	localparam logic [1:0] ST_EVICT_EMPTY    = 2'd3;

	typedef struct packed {
		logic [1:0]           kind;
		logic [PageWidth-1:0] page;
	} cmd_t;

	typedef struct packed {
		logic [1:0]           status;
		logic [PageWidth-1:0] victim;
		logic                 victim_valid;
	} rsp_t;

endpackage

>>> hdl/lru_page_replacement.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_replacement - fully associative LRU page table
// Touch, insert and evict requests over CAPACITY resident pages kept in
// recency order; one result per request.
// ----------------------------------------------------------------------------
// One item is taken in every cycle (busy is held low). Its result is on rsp,
// with done high, for a single cycle; the request passes through cmd_s1 and
// vld_s1 and the result is then registered in rsp and done. The
// receiver cannot stall, so every result must be captured on the cycle it is
// shown. The request is registered, then all entries are compared against
// it in parallel and the page, valid and rank registers are updated together
// with the result register; the update of one item is seen by the next.
// Victim reads zero when victim_valid is low. Page numbers are held in
// the low PAGE_BITS bits, at most PageWidth.
module lru_page_replacement #(
	parameter int CAPACITY  = lpr_pkg::DefaultCapacity,
	parameter int PAGE_BITS = lpr_pkg::DefaultPageBits
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  lpr_pkg::cmd_t cmd,
	output logic          done,
	output lpr_pkg::rsp_t rsp
);

	localparam int SW = (PAGE_BITS < lpr_pkg::PageWidth) ? PAGE_BITS : lpr_pkg::PageWidth;
	localparam int RW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] Full = CW'(CAPACITY);

	logic [SW-1:0]      page_q  [CAPACITY];
	logic [CAPACITY-1:0] valid_q;
	logic [RW-1:0]      rank_q  [CAPACITY];

	logic [SW-1:0]       page_d  [CAPACITY];
	logic [CAPACITY-1:0] valid_d;
	logic [RW-1:0]       rank_d  [CAPACITY];

	lpr_pkg::cmd_t cmd_s1;
	logic          vld_s1;
	lpr_pkg::rsp_t rsp_d;

	logic [SW-1:0]       req_page;
	logic [CAPACITY-1:0] hit;
	logic [CAPACITY-1:0] lru;
	logic [CAPACITY-1:0] free_sel;
	logic [CAPACITY-1:0] tgt;
	logic [CW-1:0]       cnt;
	logic [RW-1:0]       hit_rank;
	logic [RW-1:0]       lru_rank;
	logic [SW-1:0]       lru_page;
	logic [CW-1:0]       limit;
	logic                promote;
	logic                take_free;
	logic                replace;
	logic                drop;

	assign busy     = 1'b0;
	assign req_page = cmd_s1.page[SW-1:0];
	assign lru_rank = RW'(cnt - CW'(1));

	// associative search, occupancy and lowest free entry
	always_comb begin
		cnt      = '0;
		hit      = '0;
		lru      = '0;
		free_sel = '0;
		hit_rank = '0;
		lru_page = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			cnt    = cnt + CW'(valid_q[i]);
			hit[i] = valid_q[i] && (page_q[i] == req_page);
		end
		for (int i = 0; i < CAPACITY; i++) begin
			lru[i] = valid_q[i] && (rank_q[i] == lru_rank);
			if (hit[i]) begin
				hit_rank = hit_rank | rank_q[i];
			end
			if (lru[i]) begin
				lru_page = lru_page | page_q[i];
			end
		end
		// scan downwards so the lowest invalid entry wins
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_sel    = '0;
				free_sel[i] = 1'b1;
			end
		end
	end

	// decode the request
	always_comb begin
		rsp_d.status       = lpr_pkg::ST_OK;
		rsp_d.victim       = '0;
		rsp_d.victim_valid = 1'b0;
		promote   = 1'b0;
		take_free = 1'b0;
		replace   = 1'b0;
		drop      = 1'b0;
		tgt       = '0;
		limit     = Full;
		if (vld_s1) begin
			case (cmd_s1.kind)
				lpr_pkg::KIND_TOUCH: begin
					if (hit == '0) begin
						rsp_d.status = lpr_pkg::ST_TOUCH_ABSENT;
					end else begin
						promote = 1'b1;
						tgt     = hit;
						limit   = CW'(hit_rank);
					end
				end
				lpr_pkg::KIND_INSERT: begin
					if (hit != '0) begin
						rsp_d.status = lpr_pkg::ST_INSERT_PRESENT;
					end else if (cnt != Full) begin
						promote   = 1'b1;
						take_free = 1'b1;
						tgt       = free_sel;
					end else begin
						promote                 = 1'b1;
						replace                 = 1'b1;
						tgt                     = lru;
						rsp_d.victim[SW-1:0]    = lru_page;
						rsp_d.victim_valid      = 1'b1;
					end
				end
				lpr_pkg::KIND_EVICT: begin
					if (cnt == '0) begin
						rsp_d.status = lpr_pkg::ST_EVICT_EMPTY;
					end else begin
						drop                    = 1'b1;
						tgt                     = lru;
						rsp_d.victim[SW-1:0]    = lru_page;
						rsp_d.victim_valid      = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// per-entry next state
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			page_d[i]  = page_q[i];
			valid_d[i] = valid_q[i];
			rank_d[i]  = rank_q[i];
			if (tgt[i]) begin
				if (take_free || replace) begin
					page_d[i] = req_page;
				end
				if (take_free) begin
					valid_d[i] = 1'b1;
				end
				if (drop) begin
					valid_d[i] = 1'b0;
				end
				if (promote || drop) begin
					rank_d[i] = '0;
				end
			end else if (promote && valid_q[i] && (CW'(rank_q[i]) < limit)) begin
				rank_d[i] = RW'(rank_q[i] + RW'(1));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			done    <= 1'b0;
			valid_q <= '0;
			for (int i = 0; i < CAPACITY; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			vld_s1  <= start && !busy;
			done    <= vld_s1;
			valid_q <= valid_d;
			for (int i = 0; i < CAPACITY; i++) begin
				rank_q[i] <= rank_d[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1 <= cmd;
		end
		if (vld_s1) begin
			rsp <= rsp_d;
		end
		for (int i = 0; i < CAPACITY; i++) begin
			page_q[i] <= page_d[i];
		end
	end

endmodule
